// File: design/ale_pkg.sv
// ----------------------------------------------------------------------------
// ale_pkg
// Shared types and constants for the array list engine: field widths,
// operation codes of the input transaction and the command word that the
// controller broadcasts to the row of list cells.
// ----------------------------------------------------------------------------
package ale_pkg;

  // default list capacity
  localparam int CAPACITY_DEF = 16;

  // transaction field widths
  localparam int MODE_W = 3;
  localparam int SLOT_W = 5;
  localparam int VAL_W  = 32;
  localparam int LEN_W  = 5;

  // packed stream widths, whole bytes
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_USED_W  = 1 + SLOT_W + VAL_W + LEN_W;

  // operation codes carried in the mode field
  localparam logic [MODE_W-1:0] MODE_INSERT   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LOCATE   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RETRIEVE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DUP      = 3'd4;
  localparam logic [MODE_W-1:0] MODE_PURGE    = 3'd5;

  // per-cycle command broadcast to every cell
  typedef enum logic [2:0] {
    OP_HOLD,    // keep contents, clear purge marks
    OP_INS,     // open a gap at pos and write the new value
    OP_DEL,     // close the gap at pos
    OP_ROT,     // rotate the list left over its length
    OP_DUP,     // rotate the original part, append the head at the end
    OP_PURGE    // rotate or drop the head, mark later copies of it
  } ale_op_t;

  // head of the row as seen by the controller
  typedef struct packed {
    logic             kill;
    logic [VAL_W-1:0] value;
  } ale_head_t;

endpackage

// File: design/ale_cell.sv
// ----------------------------------------------------------------------------
// ale_cell
// One list position. Holds one entry and a purge mark and picks its next
// value from itself, its left or right neighbor, the new value or the head,
// depending on the broadcast command and its own index.
// ----------------------------------------------------------------------------
module ale_cell #(
  parameter int CAPACITY = ale_pkg::CAPACITY_DEF,
  parameter int IDX      = 0,
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ale_pkg::ale_op_t           op,
  input  logic [CW-1:0]              pos,
  input  logic [CW-1:0]              n,
  input  logic [CW-1:0]              r,
  input  logic [CW-1:0]              o,
  input  logic [ale_pkg::VAL_W-1:0]  ins_value,
  input  ale_pkg::ale_head_t         head,
  input  logic [ale_pkg::VAL_W-1:0]  left_value,
  input  logic [ale_pkg::VAL_W-1:0]  right_value,
  input  logic                       right_kill,
  output logic [ale_pkg::VAL_W-1:0]  value_o,
  output logic                       kill_o
);

  localparam logic [CW-1:0] MY  = CW'(IDX);
  localparam logic [CW-1:0] MY1 = CW'(IDX + 1);

  logic [ale_pkg::VAL_W-1:0] value_r, value_nxt;
  logic                      kill_r, kill_nxt;
  logic                      match;

  // later copy of a fresh head inside the unprocessed part
  assign match = (op == ale_pkg::OP_PURGE) && !head.kill && (IDX != 0) &&
                 (MY < r) && (value_r == head.value);

  assign value_o = value_r;
  assign kill_o  = kill_r | match;

  // next entry selection
  always_comb begin
    value_nxt = value_r;
    kill_nxt  = 1'b0;
    case (op)
      ale_pkg::OP_INS: begin
        if (MY == pos) begin
          value_nxt = ins_value;
        end else if (MY > pos && MY <= n) begin
          value_nxt = left_value;
        end
      end
      ale_pkg::OP_DEL: begin
        if (MY >= pos && MY1 < n) begin
          value_nxt = right_value;
        end
      end
      ale_pkg::OP_ROT: begin
        if (MY1 < n) begin
          value_nxt = right_value;
        end else if (MY1 == n) begin
          value_nxt = head.value;
        end
      end
      ale_pkg::OP_DUP: begin
        if (MY1 < o) begin
          value_nxt = right_value;
        end else if (MY1 == o || MY == n) begin
          value_nxt = head.value;
        end
      end
      ale_pkg::OP_PURGE: begin
        if (MY1 < n) begin
          value_nxt = right_value;
          kill_nxt  = right_kill;
        end else if (MY1 == n && !head.kill) begin
          value_nxt = head.value;
        end
      end
      default: begin
        value_nxt = value_r;
      end
    endcase
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kill_r <= 1'b0;
    end else begin
      kill_r <= kill_nxt;
    end
    value_r <= value_nxt;
  end

endmodule

// File: design/ale_chain.sv
// ----------------------------------------------------------------------------
// ale_chain
// Row of CAPACITY list cells. Each cell talks to its two neighbors; cell 0
// is the head that the controller watches and that wraps around to the tail.
// ----------------------------------------------------------------------------
module ale_chain #(
  parameter int CAPACITY = ale_pkg::CAPACITY_DEF,
  localparam int CW      = $clog2(CAPACITY + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ale_pkg::ale_op_t           op,
  input  logic [CW-1:0]              pos,
  input  logic [CW-1:0]              n,
  input  logic [CW-1:0]              r,
  input  logic [CW-1:0]              o,
  input  logic [ale_pkg::VAL_W-1:0]  ins_value,
  output ale_pkg::ale_head_t         head
);

  logic [ale_pkg::VAL_W-1:0] cell_value [CAPACITY];
  logic                      cell_kill  [CAPACITY];

  // head of the row
  assign head.value = cell_value[0];
  assign head.kill  = cell_kill[0];

  // cells with neighbor links, zero beyond both ends
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic [ale_pkg::VAL_W-1:0] left_v;
    logic [ale_pkg::VAL_W-1:0] right_v;
    logic                      right_k;

    if (gi == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_value[gi-1];
    end

    if (gi == CAPACITY - 1) begin : g_last
      assign right_v = '0;
      assign right_k = 1'b0;
    end else begin : g_mid_r
      assign right_v = cell_value[gi+1];
      assign right_k = cell_kill[gi+1];
    end

    ale_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (gi)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .op          (op),
      .pos         (pos),
      .n           (n),
      .r           (r),
      .o           (o),
      .ins_value   (ins_value),
      .head        (head),
      .left_value  (left_v),
      .right_value (right_v),
      .right_kill  (right_k),
      .value_o     (cell_value[gi]),
      .kill_o      (cell_kill[gi])
    );
  end

endmodule

// File: design/array_list_engine_unit.sv
// ----------------------------------------------------------------------------
// array_list_engine_unit
// Ordered list of up to CAPACITY signed 32-bit values with insert, delete,
// locate, retrieve, duplicate and purge, one result per input transaction.
// ----------------------------------------------------------------------------
// The list lives in a row of cells that shift into their neighbors. Insert,
// delete, a retrieve at a position at or beyond the length and the unused
// mode codes go from acceptance straight to the result state, and the next
// transaction is taken once that state has written the result. Locate, a
// retrieve at a valid position and purge walk the list through its head cell
// once, one entry per cycle, and duplicate walks the original entries once
// before the result state. The result waits in an output register, so a new
// transaction can be accepted while it is still pending; a stalled result
// holds the next one back until it is taken. Only one transaction is in work
// at a time.
// ----------------------------------------------------------------------------
module array_list_engine_unit #(
  parameter int CAPACITY = ale_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input: mode [2:0], slot [7:3], item_value [39:8]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ale_pkg::IN_TDATA_W-1:0]   in_tdata,
  // output: ok [0], found_slot [5:1], read_value [37:6], length [42:38]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ale_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > ale_pkg::SLOT_W) ? CW : ale_pkg::SLOT_W;
  localparam int PADW = ale_pkg::OUT_TDATA_W - ale_pkg::OUT_USED_W;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} state_t;

  // input fields
  logic [ale_pkg::MODE_W-1:0] in_mode;
  logic [ale_pkg::SLOT_W-1:0] in_slot;
  logic [ale_pkg::VAL_W-1:0]  in_value;
  logic [CMPW-1:0]            slot_x, cnt_x;

  assign in_mode  = in_tdata[2:0];
  assign in_slot  = in_tdata[7:3];
  assign in_value = in_tdata[39:8];
  assign slot_x   = CMPW'(in_slot);

  // controller state
  state_t                        state_r, state_nxt;
  logic [ale_pkg::MODE_W-1:0]    mode_r, mode_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [CW-1:0]                 k_r, k_nxt;
  logic [CW-1:0]                 r_r, r_nxt;
  logic [CW-1:0]                 o_r, o_nxt;
  logic [CW-1:0]                 slot_r, slot_nxt;
  logic [CW-1:0]                 found_r, found_nxt;
  logic [ale_pkg::VAL_W-1:0]     key_r, key_nxt;
  logic [ale_pkg::VAL_W-1:0]     rd_r, rd_nxt;
  logic                          ok_r, ok_nxt;
  logic                          hit_r, hit_nxt;
  logic                          out_tvalid_r, out_tvalid_nxt;
  logic [ale_pkg::OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  // cell row command
  ale_pkg::ale_op_t   cmd_op;
  logic [CW-1:0]      cmd_pos;
  ale_pkg::ale_head_t head;

  assign cnt_x     = CMPW'(count_r);
  assign cmd_pos   = CW'(in_slot);
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  ale_chain #(
    .CAPACITY (CAPACITY)
  ) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (cmd_op),
    .pos       (cmd_pos),
    .n         (count_r),
    .r         (r_r),
    .o         (o_r),
    .ins_value (in_value),
    .head      (head)
  );

  // sequencer next state
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    count_nxt      = count_r;
    k_nxt          = k_r;
    r_nxt          = r_r;
    o_nxt          = o_r;
    slot_nxt       = slot_r;
    found_nxt      = found_r;
    key_nxt        = key_r;
    rd_nxt         = rd_r;
    ok_nxt         = ok_r;
    hit_nxt        = hit_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    cmd_op         = ale_pkg::OP_HOLD;

    // result taken downstream
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          mode_nxt  = in_mode;
          key_nxt   = in_value;
          slot_nxt  = CW'(in_slot);
          k_nxt     = '0;
          hit_nxt   = 1'b0;
          found_nxt = '0;
          rd_nxt    = '0;
          ok_nxt    = 1'b0;
          state_nxt = S_DONE;
          unique case (in_mode)
            ale_pkg::MODE_INSERT: begin
              if (count_r < CW'(CAPACITY) && slot_x <= cnt_x) begin
                cmd_op    = ale_pkg::OP_INS;
                count_nxt = count_r + CW'(1);
                ok_nxt    = 1'b1;
              end
            end
            ale_pkg::MODE_DELETE: begin
              if (slot_x < cnt_x) begin
                cmd_op    = ale_pkg::OP_DEL;
                count_nxt = count_r - CW'(1);
                ok_nxt    = 1'b1;
              end
            end
            ale_pkg::MODE_LOCATE: begin
              found_nxt = count_r;
              state_nxt = S_WALK;
            end
            ale_pkg::MODE_RETRIEVE: begin
              if (slot_x < cnt_x) begin
                ok_nxt    = 1'b1;
                state_nxt = S_WALK;
              end
            end
            ale_pkg::MODE_DUP: begin
              o_nxt     = count_r;
              ok_nxt    = 1'b1;
              state_nxt = S_WALK;
            end
            ale_pkg::MODE_PURGE: begin
              r_nxt     = count_r;
              ok_nxt    = 1'b1;
              state_nxt = S_WALK;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_WALK: begin
        case (mode_r) inside
          // full rotation through the head, watching each entry pass
          ale_pkg::MODE_LOCATE, ale_pkg::MODE_RETRIEVE: begin
            if (k_r == count_r) begin
              state_nxt = S_DONE;
            end else begin
              cmd_op = ale_pkg::OP_ROT;
              k_nxt  = k_r + CW'(1);
              if (mode_r == ale_pkg::MODE_LOCATE) begin
                if (!hit_r && head.value == key_r) begin
                  hit_nxt   = 1'b1;
                  ok_nxt    = 1'b1;
                  found_nxt = k_r;
                end
              end else if (k_r == slot_r) begin
                rd_nxt = head.value;
              end
            end
          end
          // rotate the original entries once, appending while room is left
          ale_pkg::MODE_DUP: begin
            if (k_r == o_r) begin
              state_nxt = S_DONE;
            end else begin
              cmd_op = ale_pkg::OP_DUP;
              k_nxt  = k_r + CW'(1);
              if (count_r < CW'(CAPACITY)) begin
                count_nxt = count_r + CW'(1);
              end
            end
          end
          // keep first occurrences, drop marked copies as they reach the head
          ale_pkg::MODE_PURGE: begin
            if (r_r == '0) begin
              state_nxt = S_DONE;
            end else begin
              cmd_op = ale_pkg::OP_PURGE;
              r_nxt  = r_r - CW'(1);
              if (head.kill) begin
                count_nxt = count_r - CW'(1);
              end
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {{PADW{1'b0}}, ale_pkg::LEN_W'(count_r), rd_r,
                            ale_pkg::SLOT_W'(found_r), ok_r};
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    mode_r      <= mode_nxt;
    k_r         <= k_nxt;
    r_r         <= r_nxt;
    o_r         <= o_nxt;
    slot_r      <= slot_nxt;
    found_r     <= found_nxt;
    key_r       <= key_nxt;
    rd_r        <= rd_nxt;
    ok_r        <= ok_nxt;
    hit_r       <= hit_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

endmodule

// File: design/ale_checker.sv
// ----------------------------------------------------------------------------
// ale_checker
// Port-level checks for the array list engine, bound to the top level.
// ----------------------------------------------------------------------------
module ale_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [ale_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one transaction in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction taken while busy");

  // only a successful retrieve returns a nonzero read value
  a_read_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[37:6] != 32'd0) |-> out_tdata[0])
    else $error("read value without success");

  // no result straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // payload bits beyond the packed fields stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[47:43] == 5'd0)
    else $error("nonzero pad in result");

endmodule

bind array_list_engine_unit ale_checker u_ale_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
